/* design/mtd_pkg.sv */
// shared types, constants and morse lookup for the morse text decoder
package mtd_pkg;

	localparam int MAX_CODE_LEN_DEF = 6;
	localparam int CODE_W_MAX       = 7;
	localparam int LEN_W            = 3;
	localparam int CHAR_W           = 8;

	localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_SP   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              end_of_line;
	} result_t;

	// elements oldest in the high bit, dash = 1, right aligned
	function automatic logic [CHAR_W-1:0] morse_lookup(
		input logic [LEN_W-1:0]      len,
		input logic [CODE_W_MAX-1:0] bits
	);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_NONE;
		case ({len, bits})
			{3'd1, 7'd0}:  ch = "E";
			{3'd1, 7'd1}:  ch = "T";
			{3'd2, 7'd0}:  ch = "I";
			{3'd2, 7'd1}:  ch = "A";
			{3'd2, 7'd2}:  ch = "N";
			{3'd2, 7'd3}:  ch = "M";
			{3'd3, 7'd0}:  ch = "S";
			{3'd3, 7'd1}:  ch = "U";
			{3'd3, 7'd2}:  ch = "R";
			{3'd3, 7'd3}:  ch = "W";
			{3'd3, 7'd4}:  ch = "D";
			{3'd3, 7'd5}:  ch = "K";
			{3'd3, 7'd6}:  ch = "G";
			{3'd3, 7'd7}:  ch = "O";
			{3'd4, 7'd0}:  ch = "H";
			{3'd4, 7'd1}:  ch = "V";
			{3'd4, 7'd2}:  ch = "F";
			{3'd4, 7'd4}:  ch = "L";
			{3'd4, 7'd6}:  ch = "P";
			{3'd4, 7'd7}:  ch = "J";
			{3'd4, 7'd8}:  ch = "B";
			{3'd4, 7'd9}:  ch = "X";
			{3'd4, 7'd10}: ch = "C";
			{3'd4, 7'd11}: ch = "Y";
			{3'd4, 7'd12}: ch = "Z";
			{3'd4, 7'd13}: ch = "Q";
			{3'd5, 7'd0}:  ch = "5";
			{3'd5, 7'd1}:  ch = "4";
			{3'd5, 7'd3}:  ch = "3";
			{3'd5, 7'd7}:  ch = "2";
			{3'd5, 7'd8}:  ch = "&";
			{3'd5, 7'd10}: ch = "+";
			{3'd5, 7'd15}: ch = "1";
			{3'd5, 7'd16}: ch = "6";
			{3'd5, 7'd17}: ch = "=";
			{3'd5, 7'd18}: ch = "/";
			{3'd5, 7'd22}: ch = "(";
			{3'd5, 7'd24}: ch = "7";
			{3'd5, 7'd28}: ch = "8";
			{3'd5, 7'd30}: ch = "9";
			{3'd5, 7'd31}: ch = "0";
			{3'd6, 7'd12}: ch = "?";
			{3'd6, 7'd13}: ch = "_";
			{3'd6, 7'd18}: ch = 8'h22;
			{3'd6, 7'd21}: ch = ".";
			{3'd6, 7'd26}: ch = "@";
			{3'd6, 7'd30}: ch = 8'h27;
			{3'd6, 7'd33}: ch = "-";
			{3'd6, 7'd42}: ch = ";";
			{3'd6, 7'd43}: ch = "!";
			{3'd6, 7'd45}: ch = ")";
			{3'd6, 7'd51}: ch = ",";
			{3'd6, 7'd56}: ch = ":";
			default:       ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

/* design/mtd_char_if.sv */
// valid/ready channel carrying one input text byte
interface mtd_char_if;
	import mtd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

/* design/mtd_result_if.sv */
// valid/ready channel carrying one decoded result
interface mtd_result_if;
	import mtd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              end_of_line;

	modport source (output valid, output out_char, output end_of_line, input ready);
	modport sink   (input valid, input out_char, input end_of_line, output ready);
endinterface

/* design/morse_text_decoder.sv */
// morse text decoder top level: input register, decode logic, two-entry result queue
//
// Decodes Morse code sent as text bytes ('.', '-', space, newline) into ASCII.
// A byte is registered on transfer and decoded from that register once the
// result queue has room for all of its results (zero, one or two), which are
// then written into the two-entry result queue. One byte is taken per cycle
// as long as the queue has room for the byte's results. The output channel
// moves one result per cycle while ready is high, so a newline that closes a
// pending symbol gives two results. Unknown or spoiled patterns decode to
// 0x00; a newline ends the line and clears the symbol and gap state.
module morse_text_decoder #(
	parameter int MAX_CODE_LEN = mtd_pkg::MAX_CODE_LEN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mtd_char_if.sink    text,
	mtd_result_if.source result
);
	import mtd_pkg::*;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// symbol state
	logic [MAX_CODE_LEN-1:0] code_bits_q;
	logic [LEN_W-1:0]        code_len_q;
	logic                    bad_q;
	logic                    gap_q;

	// result queue, entry 0 is the head
	result_t    queue_q [2];
	logic [1:0] count_q;

	logic                    pending;
	logic [CHAR_W-1:0]       sym_char;
	logic [1:0]              n_res;
	result_t                 res0, res1;
	logic [MAX_CODE_LEN-1:0] code_bits_d;
	logic [LEN_W-1:0]        code_len_d;
	logic                    bad_d, gap_d;
	logic                    pop, advance;
	logic [1:0]              count_kept;
	logic [2:0]              count_total;
	result_t                 base0, base1;
	result_t                 queue_d [2];
	logic [1:0]              count_d;

	assign pending  = (code_len_q != '0) || bad_q;
	assign sym_char = pending && !bad_q ?
		morse_lookup(code_len_q, CODE_W_MAX'(code_bits_q)) : CHAR_NONE;

	always_comb begin
		n_res       = 2'd0;
		res0        = '{out_char: sym_char, end_of_line: 1'b0};
		res1        = '{out_char: CHAR_NL, end_of_line: 1'b1};
		code_bits_d = code_bits_q;
		code_len_d  = code_len_q;
		bad_d       = bad_q;
		gap_d       = gap_q;
		case (char_s1)
			CHAR_NL: begin
				if (pending) begin
					n_res = 2'd2;
				end else begin
					n_res = 2'd1;
					res0  = res1;
				end
				code_bits_d = '0;
				code_len_d  = '0;
				bad_d       = 1'b0;
				gap_d       = 1'b0;
			end
			CHAR_SP: begin
				if (gap_q) begin
					n_res = 2'd1;
					res0  = '{out_char: CHAR_SP, end_of_line: 1'b0};
					gap_d = 1'b0;
				end else begin
					if (pending) begin
						n_res       = 2'd1;
						code_bits_d = '0;
						code_len_d  = '0;
						bad_d       = 1'b0;
					end
					gap_d = 1'b1;
				end
			end
			CHAR_DOT, CHAR_DASH: begin
				gap_d = 1'b0;
				if (code_len_q >= LEN_W'(MAX_CODE_LEN)) begin
					bad_d = 1'b1;
				end else begin
					code_bits_d = {code_bits_q[MAX_CODE_LEN-2:0], char_s1 == CHAR_DASH};
					code_len_d  = code_len_q + 1'b1;
				end
			end
			default: begin
				gap_d = 1'b0;
				bad_d = 1'b1;
			end
		endcase
	end

	// a byte is decoded only when the queue can hold all its results
	assign pop         = result.valid && result.ready;
	assign count_kept  = count_q - {1'b0, pop};
	assign count_total = {1'b0, count_kept} + {1'b0, n_res};
	assign advance     = valid_s1 && (count_total <= 3'd2);
	assign text.ready  = !valid_s1 || advance;

	assign result.valid       = count_q != 2'd0;
	assign result.out_char    = queue_q[0].out_char;
	assign result.end_of_line = queue_q[0].end_of_line;

	always_comb begin
		base0 = pop ? queue_q[1] : queue_q[0];
		base1 = queue_q[1];
		queue_d[0] = base0;
		queue_d[1] = base1;
		count_d    = count_kept;
		if (advance) begin
			count_d = count_total[1:0];
			case (count_kept)
				2'd0: begin
					queue_d[0] = res0;
					queue_d[1] = res1;
				end
				2'd1: begin
					queue_d[1] = res0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			code_bits_q <= '0;
			code_len_q  <= '0;
			bad_q       <= 1'b0;
			gap_q       <= 1'b0;
			count_q     <= 2'd0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (advance) begin
				code_bits_q <= code_bits_d;
				code_len_q  <= code_len_d;
				bad_q       <= bad_d;
				gap_q       <= gap_d;
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.in_char;
		end
		queue_q[0] <= queue_d[0];
		queue_q[1] <= queue_d[1];
	end

endmodule

/* bench/morse_text_decoder_tb.sv */
// testbench for the morse text decoder: directed and random text checked against a decoding model
module morse_text_decoder_tb;
	import mtd_pkg::*;

	localparam int CODE_LEN    = MAX_CODE_LEN_DEF;
	localparam int NUM_SYMBOLS = 53;
	localparam int STALL_PCT   = 18;
	localparam int WATCHDOG    = 5000;
	localparam int END_WAIT    = 20;

	// international table: patterns and their characters in the same order
	string morse_code [NUM_SYMBOLS] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----.",
		".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
		"-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
		"..--.-", ".-..-.", ".--.-."
	};
	string morse_text = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"@";

	logic clk = 1'b0;
	logic arst_n;

	mtd_char_if   text_ch ();
	mtd_result_if result_ch ();

	morse_text_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	// decoder model state
	logic [CODE_LEN-1:0] sym_bits = '0;
	logic [LEN_W-1:0]    sym_len  = '0;
	logic                sym_bad  = 1'b0;
	logic                gap_open = 1'b0;

	result_t decoded_q [$];
	result_t head;

	bit [NUM_SYMBOLS-1:0] symbol_hits = '0;
	bit                   steady      = 1'b0;
	int                   errors       = 0;
	int                   items_sent   = 0;
	int                   results_seen = 0;
	int                   idle_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic logic [CHAR_W-1:0] symbol_char();
		int                  n;
		logic [CODE_LEN-1:0] b;
		if (sym_bad || sym_len == 0) return CHAR_NONE;
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			n = morse_code[i].len();
			b = '0;
			for (int k = 0; k < n; k++) b = {b[CODE_LEN-2:0], morse_code[i][k] == CHAR_DASH};
			if (n == sym_len && b == sym_bits) return morse_text[i];
		end
		return CHAR_NONE;
	endfunction

	function automatic void queue_result(input logic [CHAR_W-1:0] ch, input logic eol);
		result_t r;
		r.out_char    = ch;
		r.end_of_line = eol;
		decoded_q.push_back(r);
	endfunction

	function automatic void clear_symbol();
		sym_bits = '0;
		sym_len  = '0;
		sym_bad  = 1'b0;
	endfunction

	function automatic void decode_char(input logic [CHAR_W-1:0] c);
		logic busy;
		busy = (sym_len != 0) || sym_bad;
		if (c == CHAR_NL) begin
			if (busy) queue_result(symbol_char(), 1'b0);
			queue_result(CHAR_NL, 1'b1);
			clear_symbol();
			gap_open = 1'b0;
		end else if (c == CHAR_SP) begin
			if (gap_open) begin
				queue_result(CHAR_SP, 1'b0);
				gap_open = 1'b0;
			end else begin
				if (busy) begin
					queue_result(symbol_char(), 1'b0);
					clear_symbol();
				end
				gap_open = 1'b1;
			end
		end else begin
			gap_open = 1'b0;
			if (c == CHAR_DOT || c == CHAR_DASH) begin
				// past the longest symbol the length holds and the symbol is spoiled
				if (sym_len >= CODE_LEN) begin
					sym_bad = 1'b1;
				end else begin
					sym_bits = {sym_bits[CODE_LEN-2:0], c == CHAR_DASH};
					sym_len  = sym_len + 1'b1;
				end
			end else begin
				sym_bad = 1'b1;
			end
		end
	endfunction

	// valid stays high between back-to-back bytes, it only drops in an idle gap
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.in_char <= c;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		decode_char(c);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	task automatic send_random_piece();
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			idx = $urandom_range(0, NUM_SYMBOLS - 1);
			symbol_hits[idx] = 1'b1;
			send_text(morse_code[idx]);
			send_char($urandom_range(0, 9) < 8 ? CHAR_SP : CHAR_NL);
		end else if (pick < 67) begin
			// arbitrary patterns, one element past the longest now and then
			repeat ($urandom_range(1, CODE_LEN + 1))
				send_char($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT);
			send_char(CHAR_SP);
		end else if (pick < 77) begin
			repeat ($urandom_range(1, 4)) send_char(CHAR_SP);
		end else if (pick < 87) begin
			send_char(CHAR_NL);
		end else begin
			send_char(CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_gaps();
		// leading space, word space, third space, then a newline drops the open gap
		send_text("   \n");
	endtask

	task automatic test_newline_flush();
		send_text(".-\n");
	endtask

	task automatic test_overlong();
		send_text("------- ");
	endtask

	task automatic test_unknown();
		send_text("..-- ");
	endtask

	task automatic test_foreign();
		send_char(CHAR_DOT);
		send_char(8'hFF);
		send_char(CHAR_SP);
		send_char(8'h00);
		send_char(CHAR_NL);
	endtask

	task automatic test_random_text(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) send_random_piece();
	endtask

	task automatic test_steady_stretch();
		steady = 1'b1;
		test_random_text(300);
		steady = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (6) begin
			test_random_text(50);
			text_ch.valid <= 1'b0;
			do @(posedge clk); while (decoded_q.size() != 0);
		end
	endtask

	always @(posedge clk) begin
		result_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result out_char 0x%02h end_of_line %0b",
					result_ch.out_char, result_ch.end_of_line));
			end else begin
				head = decoded_q.pop_front();
				if (result_ch.out_char !== head.out_char)
					report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
						result_ch.out_char, head.out_char));
				if (result_ch.end_of_line !== head.end_of_line)
					report_mismatch($sformatf("end_of_line %0b, expected %0b",
						result_ch.end_of_line, head.end_of_line));
			end
		end
	end

	// counts cycles without any transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					WATCHDOG, decoded_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		text_ch.valid   = 1'b0;
		text_ch.in_char = '0;
		result_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gaps();
		test_newline_flush();
		test_overlong();
		test_unknown();
		test_foreign();
		test_random_text(1000);
		test_steady_stretch();
		test_drain_pause();

		text_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);

		$display("sent %0d text bytes, checked %0d decoded results", items_sent, results_seen);
		$display("table symbols hit %0d of %0d, plus gaps, flushes, spoiled and unknown symbols",
			$countones(symbol_hits), NUM_SYMBOLS);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
design/mtd_pkg.sv
design/mtd_char_if.sv
design/mtd_result_if.sv
design/morse_text_decoder.sv
bench/morse_text_decoder_tb.sv
